// File: rtl/can_bts_pkg.sv
package can_bts_pkg;

  // Field and register widths.
  localparam int unsigned CLK_W  = 28;
  localparam int unsigned RATE_W = 20;
  localparam int unsigned ACH_W  = 21;
  localparam int unsigned SJW_W  = 2;
  localparam int unsigned PCT_W  = 7;

  // Half the oscillator clock fits in one bit less than the clock itself.
  localparam int unsigned DIV_W  = CLK_W - 1;

  // Signed working width of the segment split; covers every allowed limit.
  localparam int unsigned SEG_W  = 8;

  localparam logic [ACH_W-1:0] RATE_SAT = ACH_W'(2000000);
  localparam int unsigned      CAND_MIN = 4;

  // x / 100 equals (x * 1311) >> 17 for every x below 4681, which covers the
  // largest percent times the largest bit length.
  localparam int unsigned      PCT_RECIP       = 1311;
  localparam int unsigned      PCT_RECIP_SHIFT = 17;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLOCK_HZ   = 2'd0;
  localparam logic [1:0] CFG_SJW        = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_PCT = 2'd2;
  localparam logic [1:0] CFG_TRIPLE     = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_WAIT1,
    ST_DIV2,
    ST_WAIT2,
    ST_NEXT,
    ST_JUDGE,
    ST_OUT
  } bts_state_e;

  typedef struct packed {
    logic [2:0] seg2;
    logic [3:0] seg1;
  } seg_t;

endpackage

// File: rtl/can_bts_div.sv
module can_bts_div
  import can_bts_pkg::*;
#(
  parameter int unsigned DW = 27
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    rem_q, rem_d;
  logic [DW-1:0]    dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dsr_q};
    if (diff[DW]) begin
      rem_d = shifted[DW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b0};
    end else begin
      rem_d = diff[DW-1:0];
      quo_d = {quo_q[DW-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/can_bts_seg.sv
module can_bts_seg
  import can_bts_pkg::*;
#(
  parameter int unsigned SEG1_MAX = 15,
  parameter int unsigned SEG2_MAX = 7,
  parameter int unsigned QW       = 5
) (
  input  logic [QW-1:0]    quanta_i,
  input  logic [SEG_W-1:0] pct_quot_i,
  output seg_t             seg_o
);

  localparam logic signed [SEG_W-1:0] S1_MAX = SEG_W'(SEG1_MAX);
  localparam logic signed [SEG_W-1:0] S2_MAX = SEG_W'(SEG2_MAX);
  localparam logic signed [SEG_W-1:0] TWO    = SEG_W'(2);

  logic signed [SEG_W-1:0] len;
  logic signed [SEG_W-1:0] s1;
  logic signed [SEG_W-1:0] s2;

  always_comb begin
    len = $signed(SEG_W'(quanta_i)) - SEG_W'(1);
    s2  = len - $signed(pct_quot_i);
    if (s2 < 0) begin
      s2 = '0;
    end
    if (s2 > S2_MAX) begin
      s2 = S2_MAX;
    end
    s1 = len - s2 - TWO;
    // Segment 1 out of range pins it and hands the remainder to segment 2.
    if (s1 > S1_MAX) begin
      s1 = S1_MAX;
      s2 = len - s1 - TWO;
    end else if (s1 < 0) begin
      s1 = '0;
      s2 = len - TWO;
    end
    if (s2 < 0) begin
      s2 = '0;
    end
    if (s2 > S2_MAX) begin
      s2 = S2_MAX;
    end
    seg_o.seg2 = s2[2:0];
    seg_o.seg1 = s1[3:0];
  end

endmodule

// File: rtl/can_bit_timing_search.sv
// CAN bit-timing search.
// A request on the input channel carries a bit rate (bit_rate_i), taken when
// in_valid_i is high and in_stall_o is low. The block then tries every bit
// length in turn, with the prescaler rounded down and rounded up, against half
// the configured oscillator clock, and answers with one result: the two timing
// bytes, the rate actually reached and a status bit (1 when the rate cannot be
// met within ten percent, with all other fields zero).
// Both divisions of a candidate go through one restoring divider of 27 steps.
// A candidate whose prescaler does not fit skips the second division, and all
// 46 candidates are always tried before out_valid_o rises; a zero rate is
// answered in the cycle after its acceptance.
// One request is worked on at a time; in_stall_o is high from acceptance until
// the result has been taken, and the next request can be taken in the cycle after.
// The result waits in its output registers with out_valid_o high for as long
// as out_stall_i is high; nothing else moves meanwhile.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, and should only be written while no request is in progress.
// Reset returns the registers to a 16 MHz clock, jump width 0, sample point 75
// percent, single sampling, and leaves the block idle.
module can_bit_timing_search
  import can_bts_pkg::*;
#(
  parameter int unsigned SEG1_MAX     = 15,
  parameter int unsigned SEG2_MAX     = 7,
  parameter int unsigned PRESCALE_MAX = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CLK_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [RATE_W-1:0] bit_rate_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        timing_byte0_o,
  output logic [7:0]        timing_byte1_o,
  output logic [ACH_W-1:0]  achieved_rate_o,
  output logic              status_o
);

  localparam int unsigned CAND_MAX = (SEG2_MAX + SEG1_MAX + 2) * 2 + 1;
  localparam int unsigned CW       = $clog2(CAND_MAX + 1);
  localparam int unsigned QW       = $clog2(SEG1_MAX + SEG2_MAX + 4);
  localparam int unsigned PW       = $clog2(PRESCALE_MAX + 1);
  localparam int unsigned EW       = DIV_W + 4;
  localparam int unsigned PSW      = PCT_RECIP_SHIFT + SEG_W;

  // Configuration registers.
  logic [CLK_W-1:0] clock_q;
  logic [SJW_W-1:0] sjw_q;
  logic [PCT_W-1:0] pct_q;
  logic             triple_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q  <= CLK_W'(16000000);
      sjw_q    <= '0;
      pct_q    <= PCT_W'(75);
      triple_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLOCK_HZ:   clock_q  <= cfg_wdata_i;
        CFG_SJW:        sjw_q    <= cfg_wdata_i[SJW_W-1:0];
        CFG_SAMPLE_PCT: pct_q    <= cfg_wdata_i[PCT_W-1:0];
        CFG_TRIPLE:     triple_q <= cfg_wdata_i[0];
        default:        ;
      endcase
    end
  end

  bts_state_e state_q, state_d;

  logic [RATE_W-1:0] rate_q;
  logic [DIV_W-1:0]  half_q;
  logic [CW-1:0]     cand_q;
  logic [PW-1:0]     div_q;
  logic              found_q;
  logic [DIV_W-1:0]  best_err_q;
  logic [QW-1:0]     best_quanta_q;
  logic [5:0]        best_div_q;
  logic [DIV_W-1:0]  win_rate_q;
  logic [7:0]        byte0_q, byte1_q;
  logic [ACH_W-1:0]  ach_q;
  logic              status_q;

  logic              in_accept;
  logic [QW-1:0]     quanta;
  logic [DIV_W:0]    presc;
  logic              presc_bad;
  logic [DIV_W-1:0]  rate_ext;
  logic [DIV_W-1:0]  err;
  logic              judge_fail;
  logic [EW-1:0]     err_x10;
  logic [PCT_W+QW-1:0] pct_prod;
  logic [PSW-1:0]    pct_scaled;
  logic [SEG_W-1:0]  pct_quot;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  seg_t              seg;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign quanta    = QW'(cand_q >> 1) + QW'(1);
  assign presc     = {1'b0, div_quot} + (DIV_W+1)'(cand_q[0]);
  assign presc_bad = (presc == '0) || (presc > (DIV_W+1)'(PRESCALE_MAX));
  assign rate_ext  = DIV_W'(rate_q);
  assign err       = (div_quot > rate_ext) ? div_quot - rate_ext : rate_ext - div_quot;
  assign err_x10   = {1'b0, best_err_q, 3'b000} + {3'b000, best_err_q, 1'b0};
  // rate / err < 10 is the same test as rate < 10 * err.
  assign judge_fail = !found_q || (EW'(rate_q) < err_x10);

  // Sample-point product divided by 100 through a reciprocal multiplication.
  assign pct_prod   = pct_q * best_quanta_q;
  assign pct_scaled = PSW'(pct_prod) * PSW'(PCT_RECIP);
  assign pct_quot   = pct_scaled[PCT_RECIP_SHIFT +: SEG_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = half_q;
    div_divisor  = DIV_W'(quanta * rate_q);
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (bit_rate_i == '0) ? ST_OUT : ST_DIV1;
        end
      end
      ST_DIV1: begin
        div_start = 1'b1;
        state_d   = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (div_done) begin
          state_d = presc_bad ? ST_NEXT : ST_DIV2;
        end
      end
      ST_DIV2: begin
        div_start   = 1'b1;
        div_divisor = DIV_W'(div_q * quanta);
        state_d     = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (div_done) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_d = (cand_q == CW'(CAND_MAX)) ? ST_JUDGE : ST_DIV1;
      end
      ST_JUDGE: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          rate_q   <= bit_rate_i;
          half_q   <= clock_q[CLK_W-1:1];
          cand_q   <= CW'(CAND_MIN);
          found_q  <= 1'b0;
          byte0_q  <= '0;
          byte1_q  <= '0;
          ach_q    <= '0;
          status_q <= STATUS_FAIL;
        end
      end
      ST_WAIT1: begin
        if (div_done) begin
          div_q <= presc[PW-1:0];
        end
      end
      ST_WAIT2: begin
        // A tie goes to the later candidate.
        if (div_done && (!found_q || err <= best_err_q)) begin
          found_q       <= 1'b1;
          best_err_q    <= err;
          best_quanta_q <= quanta;
          best_div_q    <= 6'(div_q - PW'(1));
          win_rate_q    <= div_quot;
        end
      end
      ST_NEXT: begin
        cand_q <= cand_q + CW'(1);
      end
      ST_JUDGE: begin
        if (!judge_fail) begin
          byte0_q  <= {sjw_q, best_div_q};
          byte1_q  <= {triple_q, seg.seg2, seg.seg1};
          ach_q    <= (win_rate_q > DIV_W'(RATE_SAT)) ? RATE_SAT : win_rate_q[ACH_W-1:0];
          status_q <= STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  can_bts_div #(
    .DW(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  can_bts_seg #(
    .SEG1_MAX (SEG1_MAX),
    .SEG2_MAX (SEG2_MAX),
    .QW       (QW)
  ) u_seg (
    .quanta_i   (best_quanta_q),
    .pct_quot_i (pct_quot),
    .seg_o      (seg)
  );

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign timing_byte0_o  = byte0_q;
  assign timing_byte1_o  = byte1_q;
  assign achieved_rate_o = ach_q;
  assign status_o        = status_q;

  a_no_accept_while_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o
  ) else $error("request accepted while a result is pending");

  a_divider_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (state_q == ST_IDLE) |-> !div_busy
  ) else $error("divider busy while the block is idle");

  a_fail_clears_fields: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && status_o) |->
        (timing_byte0_o == '0 && timing_byte1_o == '0 && achieved_rate_o == '0)
  ) else $error("failed result carries non-zero fields");

  a_success_has_rate: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !status_o) |-> (achieved_rate_o != '0)
  ) else $error("successful result with zero achieved rate");

endmodule
